### design/rsh_pkg.sv
// ----------------------------------------------------------------------------
// rsh_pkg
// Shared types and constants for the running statistics and histogram block.
// ----------------------------------------------------------------------------
package rsh_pkg;

    // Statistics word width
    localparam int STAT_W = 64;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd4;

    localparam int BINS_REG_W  = 7;
    localparam int SCALE_W     = 32;
    localparam int OUT_BIN_W   = 32;

    // Log2 format: Q6.16, mantissa Q1.31, product Q14.40
    localparam int LOG_INT_W  = 6;
    localparam int LOG_FRAC_W = 16;
    localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
    localparam int MANT_W     = 32;
    localparam int PROD_W     = 2 * MANT_W;
    localparam int P_FRAC_W   = 40;

    // Item functions
    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_INC   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    // Binning configuration seen by the bin unit
    typedef struct packed {
        logic [STAT_W-1:0]  low;
        logic [STAT_W-1:0]  high;
        logic               log_mode;
        logic [SCALE_W-1:0] scale;
    } bin_cfg_t;

endpackage

### design/running_stats_histogram.sv
// ----------------------------------------------------------------------------
// running_stats_histogram
// Running statistics over 64-bit values with a saturating histogram.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and gives one result. Increment,
// clear and a set with the histogram disabled go straight to the output
// stage; a bin read within the bins in use first passes through the
// registered store read. A set with the histogram enabled runs the bin
// unit. A value at or beyond an edge is binned without the multiplier.
// Linear binning forms two halves of the product on the shared 32x32
// multiplier, then finds one quotient bit per cycle. Log binning runs two
// log2 evaluations, each of 6 normalise steps and then repeated squarings
// on that multiplier, then one scale product. A set whose value misses
// every bin skips the store update. The input is ready again at the edge
// that raises the result valid. The histogram store is emptied at once by
// reset, by a clear and by a write to any listed configuration register,
// through per-bin valid bits, so no clearing pass is needed. A new
// transaction is accepted while the previous result still waits to be
// taken.
// ----------------------------------------------------------------------------
module running_stats_histogram #(
    parameter int MAX_BINS        = 64,
    parameter int BIN_COUNT_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Item input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [rsh_pkg::STAT_W-1:0]          sample,
    input  logic [$clog2(MAX_BINS)-1:0]         bin_select,
    // Result output
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rsh_pkg::STAT_W-1:0]          current_value,
    output logic [rsh_pkg::STAT_W-1:0]          total,
    output logic [rsh_pkg::STAT_W-1:0]          item_count,
    output logic [rsh_pkg::STAT_W-1:0]          lowest,
    output logic [rsh_pkg::STAT_W-1:0]          highest,
    output logic [rsh_pkg::OUT_BIN_W-1:0]       bin_value,
    output logic [$clog2(MAX_BINS+1)-1:0]       bin_hit,
    // Configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsh_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsh_pkg::STAT_W-1:0]          cfg_data
);

    localparam int HW = $clog2(MAX_BINS + 1);
    localparam int SW = $clog2(MAX_BINS);
    localparam int BW = BIN_COUNT_WIDTH;
    localparam logic [HW-1:0] NO_BIN = HW'(MAX_BINS);
    localparam int EXT_W = HW + rsh_pkg::BINS_REG_W;

    typedef enum logic [2:0] {
        T_IDLE,
        T_BIN,
        T_RD,
        T_INC,
        T_OUT
    } tstate_t;

    tstate_t                          state_reg;

    // Configuration registers
    logic [rsh_pkg::BINS_REG_W-1:0]   bins_reg;
    logic [rsh_pkg::STAT_W-1:0]       low_reg;
    logic [rsh_pkg::STAT_W-1:0]       high_reg;
    logic                             log_reg;
    logic [rsh_pkg::SCALE_W-1:0]      scale_reg;

    // Statistics
    logic [rsh_pkg::STAT_W-1:0]       value_reg;
    logic [rsh_pkg::STAT_W-1:0]       sum_reg;
    logic [rsh_pkg::STAT_W-1:0]       count_reg;
    logic [rsh_pkg::STAT_W-1:0]       min_reg;
    logic [rsh_pkg::STAT_W-1:0]       max_reg;

    // Pending result fields
    logic [BW-1:0]                    bval_reg;
    logic [HW-1:0]                    hit_reg;

    // Output register
    logic                             out_valid_reg;
    logic [rsh_pkg::STAT_W-1:0]       o_value_reg;
    logic [rsh_pkg::STAT_W-1:0]       o_total_reg;
    logic [rsh_pkg::STAT_W-1:0]       o_count_reg;
    logic [rsh_pkg::STAT_W-1:0]       o_low_reg;
    logic [rsh_pkg::STAT_W-1:0]       o_high_reg;
    logic [rsh_pkg::OUT_BIN_W-1:0]    o_bval_reg;
    logic [HW-1:0]                    o_hit_reg;

    logic [HW-1:0]                    nb_c;
    logic                             in_acc;
    logic                             cfg_acc;
    logic                             cfg_hit_reg_c;
    rsh_pkg::func_t                   func_c;
    rsh_pkg::bin_cfg_t                bcfg;
    logic                             unit_start;
    logic                             unit_done;
    logic [HW-1:0]                    unit_hit;
    logic                             mem_clear;
    logic                             mem_we;
    logic [SW-1:0]                    mem_raddr;
    logic [BW-1:0]                    mem_rdata;
    logic [BW+rsh_pkg::OUT_BIN_W-1:0] bval_ext;
    logic                             out_free;

    // Bins in use, capped at the store depth
    assign nb_c = ((EXT_W'(bins_reg)) > (EXT_W'(MAX_BINS))) ? HW'(MAX_BINS) : HW'(bins_reg);

    assign func_c    = rsh_pkg::func_t'(func);
    assign in_ready  = (state_reg == T_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Only writes to a listed register count as reconfiguration
    assign cfg_hit_reg_c = (cfg_index == rsh_pkg::CFG_BINS) || (cfg_index == rsh_pkg::CFG_LOW)
                        || (cfg_index == rsh_pkg::CFG_HIGH) || (cfg_index == rsh_pkg::CFG_LOG)
                        || (cfg_index == rsh_pkg::CFG_SCALE);

    assign bcfg.low      = low_reg;
    assign bcfg.high     = high_reg;
    assign bcfg.log_mode = log_reg;
    assign bcfg.scale    = scale_reg;

    assign unit_start = in_acc && (func_c == rsh_pkg::FUNC_SET) && (nb_c != '0);
    assign mem_clear  = (cfg_acc && cfg_hit_reg_c) || (in_acc && func_c == rsh_pkg::FUNC_CLEAR);
    assign mem_raddr  = (state_reg == T_IDLE) ? bin_select : SW'(unit_hit);
    assign mem_we     = (state_reg == T_INC) && (mem_rdata != {BW{1'b1}});
    assign bval_ext   = {{rsh_pkg::OUT_BIN_W{1'b0}}, bval_reg};

    rsh_bin_unit #(
        .MAX_BINS (MAX_BINS)
    ) u_bin_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (unit_start),
        .sample (sample),
        .nb     (nb_c),
        .cfg    (bcfg),
        .done   (unit_done),
        .hit    (unit_hit)
    );

    rsh_bin_mem #(
        .MAX_BINS        (MAX_BINS),
        .BIN_COUNT_WIDTH (BIN_COUNT_WIDTH)
    ) u_bin_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (mem_clear),
        .we    (mem_we),
        .waddr (SW'(hit_reg)),
        .wdata (mem_rdata + BW'(1)),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_reg  <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            log_reg   <= 1'b0;
            scale_reg <= '0;
        end
        else if (cfg_acc)
        begin
            unique case (cfg_index)
                rsh_pkg::CFG_BINS:  bins_reg  <= cfg_data[rsh_pkg::BINS_REG_W-1:0];
                rsh_pkg::CFG_LOW:   low_reg   <= cfg_data;
                rsh_pkg::CFG_HIGH:  high_reg  <= cfg_data;
                rsh_pkg::CFG_LOG:   log_reg   <= cfg_data[0];
                rsh_pkg::CFG_SCALE: scale_reg <= cfg_data[rsh_pkg::SCALE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Control, statistics and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            value_reg     <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            bval_reg      <= '0;
            hit_reg       <= '0;
            out_valid_reg <= 1'b0;
            o_value_reg   <= '0;
            o_total_reg   <= '0;
            o_count_reg   <= '0;
            o_low_reg     <= '0;
            o_high_reg    <= '0;
            o_bval_reg    <= '0;
            o_hit_reg     <= '0;
        end
        else
        begin
            // T_OUT reloads the output register itself
            if (out_valid_reg && out_ready && (state_reg != T_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_acc)
                    begin
                        bval_reg <= '0;
                        hit_reg  <= NO_BIN;
                        unique case (func_c)
                            rsh_pkg::FUNC_SET,
                            rsh_pkg::FUNC_INC:
                            begin
                                value_reg <= (func_c == rsh_pkg::FUNC_SET) ? sample
                                                                           : value_reg + sample;
                                sum_reg   <= sum_reg + sample;
                                count_reg <= count_reg + rsh_pkg::STAT_W'(1);
                                if (sample < min_reg)
                                begin
                                    min_reg <= sample;
                                end
                                if (sample > max_reg)
                                begin
                                    max_reg <= sample;
                                end
                                state_reg <= unit_start ? T_BIN : T_OUT;
                            end
                            rsh_pkg::FUNC_READ:
                            begin
                                state_reg <= (HW'(bin_select) < nb_c) ? T_RD : T_OUT;
                            end
                            rsh_pkg::FUNC_CLEAR:
                            begin
                                value_reg <= '0;
                                sum_reg   <= '0;
                                count_reg <= '0;
                                min_reg   <= '1;
                                max_reg   <= '0;
                                state_reg <= T_OUT;
                            end
                            default:
                            begin
                                state_reg <= T_OUT;
                            end
                        endcase
                    end
                end
                T_BIN:
                begin
                    if (unit_done)
                    begin
                        hit_reg   <= unit_hit;
                        state_reg <= (unit_hit != NO_BIN) ? T_INC : T_OUT;
                    end
                end
                T_RD:
                begin
                    bval_reg  <= mem_rdata;
                    state_reg <= T_OUT;
                end
                T_INC:
                begin
                    state_reg <= T_OUT;
                end
                T_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_value_reg   <= value_reg;
                        o_total_reg   <= sum_reg;
                        o_count_reg   <= count_reg;
                        o_low_reg     <= (count_reg != '0) ? min_reg : '0;
                        o_high_reg    <= (count_reg != '0) ? max_reg : '0;
                        o_bval_reg    <= bval_ext[rsh_pkg::OUT_BIN_W-1:0];
                        o_hit_reg     <= hit_reg;
                        state_reg     <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign current_value = o_value_reg;
    assign total         = o_total_reg;
    assign item_count    = o_count_reg;
    assign lowest        = o_low_reg;
    assign highest       = o_high_reg;
    assign bin_value     = o_bval_reg;
    assign bin_hit       = o_hit_reg;

endmodule

### design/rsh_bin_mem.sv
// ----------------------------------------------------------------------------
// rsh_bin_mem
// Histogram bin store: one write port, one registered read port, per-entry
// valid bits so that a clear empties the whole store with no clearing pass.
// ----------------------------------------------------------------------------
module rsh_bin_mem #(
    parameter int MAX_BINS        = 64,
    parameter int BIN_COUNT_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        we,
    input  logic [$clog2(MAX_BINS)-1:0] waddr,
    input  logic [BIN_COUNT_WIDTH-1:0]  wdata,
    input  logic [$clog2(MAX_BINS)-1:0] raddr,
    output logic [BIN_COUNT_WIDTH-1:0]  rdata
);

    logic [BIN_COUNT_WIDTH-1:0] mem [MAX_BINS];
    logic [MAX_BINS-1:0]        vld_reg;
    logic [BIN_COUNT_WIDTH-1:0] rdata_reg;

    // Valid bits: cleared at reset and on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (clear)
        begin
            vld_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    // Storage array and registered read; an unwritten entry reads zero
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= vld_reg[raddr] ? mem[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

### design/rsh_bin_unit.sv
// ----------------------------------------------------------------------------
// rsh_bin_unit
// Bin index sequencer around one shared 32x32 multiplier: linear binning by
// a scaled product and a short restoring division, log binning by an
// iterative Q6.16 log2 (normalise, then 16 squarings) and a final scale.
// ----------------------------------------------------------------------------
module rsh_bin_unit #(
    parameter int MAX_BINS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rsh_pkg::STAT_W-1:0]        sample,
    input  logic [$clog2(MAX_BINS+1)-1:0]     nb,
    input  rsh_pkg::bin_cfg_t                 cfg,
    output logic                              done,
    output logic [$clog2(MAX_BINS+1)-1:0]     hit
);

    localparam int HW = $clog2(MAX_BINS + 1);
    localparam int QW = $clog2(MAX_BINS);
    localparam int NW = rsh_pkg::STAT_W + QW;
    localparam int CNTW = 5;
    localparam int CW = rsh_pkg::STAT_W - rsh_pkg::P_FRAC_W + 1;
    localparam logic [HW-1:0] NO_BIN = HW'(MAX_BINS);

    typedef enum logic [3:0] {
        U_IDLE,
        U_DECIDE,
        U_LIN_LO,
        U_LIN_HI,
        U_LIN_ACC,
        U_DIV,
        U_NORM,
        U_SQ,
        U_SCALE,
        U_SCALE_USE,
        U_DONE
    } ustate_t;

    ustate_t                          state_reg;
    logic [rsh_pkg::STAT_W-1:0]       v_reg;
    logic [rsh_pkg::STAT_W-1:0]       x_reg;
    logic [rsh_pkg::LOG_INT_W-1:0]    e_reg;
    logic [rsh_pkg::LOG_FRAC_W-1:0]   frac_reg;
    logic [rsh_pkg::LOG_W-1:0]        lh_reg;
    logic [rsh_pkg::LOG_W-1:0]        dlt_reg;
    logic                             pass_reg;
    logic [CNTW-1:0]                  cnt_reg;
    logic [NW-1:0]                    num_reg;
    logic [NW-1:0]                    dsh_reg;
    logic [QW-1:0]                    q_reg;
    logic [HW-1:0]                    hit_reg;
    logic [rsh_pkg::PROD_W-1:0]       prod_reg;

    logic [rsh_pkg::MANT_W-1:0]       mul_a;
    logic [rsh_pkg::MANT_W-1:0]       mul_b;
    logic [rsh_pkg::PROD_W-1:0]       prod_c;
    logic [rsh_pkg::STAT_W-1:0]       d_c;
    logic [rsh_pkg::STAT_W-1:0]       r_c;
    logic [rsh_pkg::MANT_W-1:0]       cur_m;
    logic [5:0]                       sh_c;
    logic [rsh_pkg::STAT_W-1:0]       mask_hi;
    logic                             top_zero;
    logic                             ge_c;
    logic [QW-1:0]                    q_new;
    logic [rsh_pkg::LOG_FRAC_W-1:0]   frac_new;
    logic [rsh_pkg::LOG_W-1:0]        log_new;
    logic [CW-1:0]                    c_c;
    logic [CW-1:0]                    nbm1_c;

    // Operand preparation
    assign d_c = v_reg - cfg.low;
    assign r_c = cfg.high - cfg.low;

    // Mantissa for the next squaring: initial normalised value or last square
    always_comb
    begin
        if (cnt_reg == '0)
        begin
            cur_m = x_reg[rsh_pkg::STAT_W-1 -: rsh_pkg::MANT_W];
        end
        else if (prod_reg[rsh_pkg::PROD_W-1])
        begin
            cur_m = prod_reg[rsh_pkg::PROD_W-1 -: rsh_pkg::MANT_W];
        end
        else
        begin
            cur_m = prod_reg[rsh_pkg::PROD_W-2 -: rsh_pkg::MANT_W];
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            U_LIN_LO:
            begin
                mul_a = d_c[rsh_pkg::MANT_W-1:0];
                mul_b = rsh_pkg::MANT_W'(nb) - rsh_pkg::MANT_W'(2);
            end
            U_LIN_HI:
            begin
                mul_a = d_c[rsh_pkg::STAT_W-1:rsh_pkg::MANT_W];
                mul_b = rsh_pkg::MANT_W'(nb) - rsh_pkg::MANT_W'(2);
            end
            U_SQ:
            begin
                mul_a = cur_m;
                mul_b = cur_m;
            end
            U_SCALE:
            begin
                mul_a = rsh_pkg::MANT_W'(dlt_reg);
                mul_b = cfg.scale;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // Normalisation step: test the top sh bits
    assign sh_c     = 6'(6'd32 >> cnt_reg);
    assign mask_hi  = ~({rsh_pkg::STAT_W{1'b1}} >> sh_c);
    assign top_zero = (x_reg & mask_hi) == '0;

    // Division step
    assign ge_c  = num_reg >= dsh_reg;
    assign q_new = QW'(q_reg << 1) | QW'(ge_c);

    // Log result once the last square is in
    assign frac_new = {frac_reg[rsh_pkg::LOG_FRAC_W-2:0], prod_reg[rsh_pkg::PROD_W-1]};
    assign log_new  = {e_reg, frac_new};

    // Ceiling of the Q14.40 product
    assign c_c    = CW'(prod_reg[rsh_pkg::PROD_W-1:rsh_pkg::P_FRAC_W])
                  + CW'(prod_reg[rsh_pkg::P_FRAC_W-1:0] != '0);
    assign nbm1_c = CW'(nb) - CW'(1);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            v_reg     <= '0;
            x_reg     <= '0;
            e_reg     <= '0;
            frac_reg  <= '0;
            lh_reg    <= '0;
            dlt_reg   <= '0;
            pass_reg  <= 1'b0;
            cnt_reg   <= '0;
            num_reg   <= '0;
            dsh_reg   <= '0;
            q_reg     <= '0;
            hit_reg   <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            prod_reg <= prod_c;
            unique case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        v_reg     <= sample;
                        state_reg <= U_DECIDE;
                    end
                end
                U_DECIDE:
                begin
                    if (v_reg <= cfg.low)
                    begin
                        hit_reg   <= '0;
                        state_reg <= U_DONE;
                    end
                    else if (v_reg >= cfg.high)
                    begin
                        hit_reg   <= nb - HW'(1);
                        state_reg <= U_DONE;
                    end
                    else if (cfg.log_mode)
                    begin
                        x_reg     <= cfg.high;
                        e_reg     <= '1;
                        pass_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= U_NORM;
                    end
                    else if (nb > HW'(2) && cfg.high > cfg.low)
                    begin
                        state_reg <= U_LIN_LO;
                    end
                    else
                    begin
                        hit_reg   <= (nb > HW'(1)) ? HW'(1) : NO_BIN;
                        state_reg <= U_DONE;
                    end
                end
                U_LIN_LO:
                begin
                    state_reg <= U_LIN_HI;
                end
                U_LIN_HI:
                begin
                    num_reg   <= NW'(prod_reg);
                    dsh_reg   <= NW'(r_c) << (QW - 1);
                    q_reg     <= '0;
                    cnt_reg   <= CNTW'(QW - 1);
                    state_reg <= U_LIN_ACC;
                end
                U_LIN_ACC:
                begin
                    num_reg   <= num_reg + (NW'(prod_reg) << rsh_pkg::MANT_W);
                    state_reg <= U_DIV;
                end
                U_DIV:
                begin
                    if (ge_c)
                    begin
                        num_reg <= num_reg - dsh_reg;
                    end
                    dsh_reg <= dsh_reg >> 1;
                    q_reg   <= q_new;
                    if (cnt_reg == '0)
                    begin
                        hit_reg   <= ((HW'(q_new) + HW'(1)) < nb) ? HW'(q_new) + HW'(1)
                                                                   : NO_BIN;
                        state_reg <= U_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNTW'(1);
                    end
                end
                U_NORM:
                begin
                    if (top_zero)
                    begin
                        x_reg <= x_reg << sh_c;
                        e_reg <= e_reg - sh_c;
                    end
                    if (cnt_reg == CNTW'(5))
                    begin
                        cnt_reg   <= '0;
                        frac_reg  <= '0;
                        state_reg <= U_SQ;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                end
                U_SQ:
                begin
                    if (cnt_reg != '0)
                    begin
                        frac_reg <= frac_new;
                    end
                    if (cnt_reg == CNTW'(rsh_pkg::LOG_FRAC_W))
                    begin
                        if (!pass_reg)
                        begin
                            lh_reg    <= log_new;
                            x_reg     <= v_reg;
                            e_reg     <= '1;
                            pass_reg  <= 1'b1;
                            cnt_reg   <= '0;
                            state_reg <= U_NORM;
                        end
                        else
                        begin
                            dlt_reg   <= (lh_reg > log_new) ? lh_reg - log_new : '0;
                            state_reg <= U_SCALE;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                    end
                end
                U_SCALE:
                begin
                    state_reg <= U_SCALE_USE;
                end
                U_SCALE_USE:
                begin
                    hit_reg   <= (c_c > nbm1_c) ? NO_BIN : nb - HW'(1) - HW'(c_c);
                    state_reg <= U_DONE;
                end
                U_DONE:
                begin
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done = (state_reg == U_DONE);
    assign hit  = hit_reg;

endmodule

### tb/running_stats_histogram_test.sv
// ----------------------------------------------------------------------------
// running_stats_histogram_test
// Self-checking bench for the running statistics and histogram block. A
// directed table covers reset state, the field extremes, every function and
// the histogram corner cases. Random traffic then runs under several bin
// settings, linear and logarithmic. Every result is compared, field by field,
// with a table expectation or a local model of the statistics and bin store.
// ----------------------------------------------------------------------------
module running_stats_histogram_test;

    localparam int  NBINS      = 64;
    localparam int  LIMIT      = 600000;
    localparam int  PHASE_LEN  = 94;
    localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [6:0]  NO_BIN = 7'd64;

    typedef struct packed {
        logic [63:0] current_value;
        logic [63:0] total;
        logic [63:0] item_count;
        logic [63:0] lowest;
        logic [63:0] highest;
        logic [31:0] bin_value;
        logic [6:0]  bin_hit;
    } stat_result_t;

    // One row of the directed table: a register write or an item
    typedef struct {
        bit                 is_reg;
        logic [2:0]         idx;
        logic [63:0]        data;
        rsh_pkg::func_t     f;
        logic [5:0]         sel;
        bit                 has_exp;
        stat_result_t       exp;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           func;
    logic [63:0]          sample;
    logic [5:0]           bin_select;
    logic                 out_valid;
    logic                 out_ready;
    logic [63:0]          current_value;
    logic [63:0]          total;
    logic [63:0]          item_count;
    logic [63:0]          lowest;
    logic [63:0]          highest;
    logic [31:0]          bin_value;
    logic [6:0]           bin_hit;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_index;
    logic [63:0]          cfg_data;

    // Typed expectation travelling with the item on the wire
    bit                   row_has_exp;
    stat_result_t         row_exp;

    // Model state
    logic [6:0]           m_bins;
    logic [63:0]          m_low;
    logic [63:0]          m_high;
    logic                 m_log;
    logic [31:0]          m_scale;
    logic [63:0]          m_value;
    logic [63:0]          m_sum;
    logic [63:0]          m_count;
    logic [63:0]          m_min;
    logic [63:0]          m_max;
    logic [31:0]          hist_count [NBINS];

    stat_result_t         pending_results [$];
    row_t                 dir_rows [$];
    int                   errors;
    int                   n_items;
    int                   n_results;
    int                   n_hits;
    int                   n_regs;
    int                   cycles;
    bit                   hold_req;

    running_stats_histogram DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .sample        (sample),
        .bin_select    (bin_select),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .current_value (current_value),
        .total         (total),
        .item_count    (item_count),
        .lowest        (lowest),
        .highest       (highest),
        .bin_value     (bin_value),
        .bin_hit       (bin_hit),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    function automatic void clear_stats();
        m_value = '0;
        m_sum   = '0;
        m_count = '0;
        m_min   = ALL1;
        m_max   = '0;
        foreach (hist_count[i]) hist_count[i] = '0;
    endfunction

    function automatic void write_model_reg(logic [2:0] idx, logic [63:0] d);
        case (idx)
            rsh_pkg::CFG_BINS:  m_bins  = d[6:0];
            rsh_pkg::CFG_LOW:   m_low   = d;
            rsh_pkg::CFG_HIGH:  m_high  = d;
            rsh_pkg::CFG_LOG:   m_log   = d[0];
            rsh_pkg::CFG_SCALE: m_scale = d[31:0];
            default:            return;
        endcase
        foreach (hist_count[i]) hist_count[i] = '0;
    endfunction

    // Q6.16 log2 by repeated squaring of a Q1.31 mantissa
    function automatic logic [63:0] log2_fix(logic [63:0] x);
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] sq;
        logic [63:0] frac;
        e    = 0;
        frac = 0;
        if (x == 0)
            return 0;
        for (int b = 0; b < 64; b++)
            if (x[b]) e = b;
        m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
        for (int i = 0; i < 16; i++)
        begin
            sq   = m * m;
            frac = frac << 1;
            if (sq[63])
            begin
                frac[0] = 1'b1;
                m = sq >> 32;
            end
            else
                m = sq >> 31;
        end
        return (e << 16) | frac;
    endfunction

    function automatic logic [6:0] bin_for(logic [63:0] v, logic [6:0] nb);
        logic [63:0]  lh;
        logic [63:0]  lv;
        logic [63:0]  dlt;
        logic [63:0]  p;
        logic [63:0]  c;
        logic [127:0] prod;
        logic [63:0]  n;
        if (v <= m_low)
            return 7'd0;
        if (v >= m_high)
            return nb - 7'd1;
        if (m_log)
        begin
            lh  = log2_fix(m_high);
            lv  = log2_fix(v);
            dlt = (lh > lv) ? lh - lv : 0;
            p   = dlt * m_scale;
            c   = (p + 64'hFF_FFFF_FFFF) >> 40;
            if (c > nb - 1)
                return NO_BIN;
            n = nb - 1 - c;
        end
        else if (nb > 2 && m_high > m_low)
        begin
            prod = 128'(v - m_low) * 128'(nb - 2);
            n    = 1 + 64'(prod / 128'(m_high - m_low));
        end
        else
            n = 1;
        return (n < nb) ? n[6:0] : NO_BIN;
    endfunction

    // Applies one item to the model and returns its result
    function automatic stat_result_t run_item(rsh_pkg::func_t f, logic [63:0] s,
                                              logic [5:0] sel);
        stat_result_t r;
        logic [6:0]   nb;
        logic [6:0]   hit;
        logic [31:0]  bval;
        nb   = (m_bins > NBINS) ? 7'(NBINS) : m_bins;
        hit  = NO_BIN;
        bval = '0;
        case (f)
            rsh_pkg::FUNC_SET:
            begin
                m_value = s;
                m_sum   = m_sum + s;
                if (s < m_min) m_min = s;
                if (s > m_max) m_max = s;
                m_count++;
                if (nb > 0)
                begin
                    hit = bin_for(s, nb);
                    if (hit < nb && hist_count[hit] != 32'hFFFF_FFFF)
                        hist_count[hit]++;
                end
            end
            rsh_pkg::FUNC_INC:
            begin
                m_value = m_value + s;
                m_sum   = m_sum + s;
                if (s < m_min) m_min = s;
                if (s > m_max) m_max = s;
                m_count++;
            end
            rsh_pkg::FUNC_READ:
                if (sel < nb) bval = hist_count[sel];
            default:
                clear_stats();
        endcase
        r.current_value = m_value;
        r.total         = m_sum;
        r.item_count    = m_count;
        r.lowest        = (m_count != 0) ? m_min : 0;
        r.highest       = (m_count != 0) ? m_max : 0;
        r.bin_value     = bval;
        r.bin_hit       = hit;
        if (hit != NO_BIN) n_hits++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report(string what, logic [63:0] exp_v, logic [63:0] got_v);
        $display("MISMATCH @%0d %s: expected %h, got %h", cycles, what, exp_v, got_v);
        errors++;
    endtask

    task automatic compare_result(stat_result_t e);
        if (current_value !== e.current_value)
            report("current_value", e.current_value, current_value);
        if (total !== e.total)
            report("total", e.total, total);
        if (item_count !== e.item_count)
            report("item_count", e.item_count, item_count);
        if (lowest !== e.lowest)
            report("lowest", e.lowest, lowest);
        if (highest !== e.highest)
            report("highest", e.highest, highest);
        if (bin_value !== e.bin_value)
            report("bin_value", 64'(e.bin_value), 64'(bin_value));
        if (bin_hit !== e.bin_hit)
            report("bin_hit", 64'(e.bin_hit), 64'(bin_hit));
    endtask

    // Monitor: tracks accepted transactions on all three channels
    always @(posedge clk)
    begin : monitor_blk
        stat_result_t r;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                write_model_reg(cfg_index, cfg_data);
                n_regs++;
            end
            if (in_valid && in_ready)
            begin
                r = run_item(rsh_pkg::func_t'(func), sample, bin_select);
                pending_results.push_back(row_has_exp ? row_exp : r);
                n_items++;
            end
            if (out_valid && out_ready)
            begin
                n_results++;
                if (pending_results.size() == 0)
                    report("unexpected result", 0, current_value);
                else
                    compare_result(pending_results.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Mostly no gap, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(rsh_pkg::func_t f, logic [63:0] s, logic [5:0] sel,
                             bit he, stat_result_t ex, bit idle_ok);
        int g;
        g = idle_ok ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        func        <= f;
        sample      <= s;
        bin_select  <= sel;
        row_has_exp <= he;
        row_exp     <= ex;
        in_valid    <= 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    // Waits for every result, then lets any bin unit work drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || out_valid) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(logic [6:0] b, logic [63:0] lo, logic [63:0] hi,
                            logic lm, logic [31:0] sc);
        wait_idle();
        write_reg(rsh_pkg::CFG_BINS, 64'(b));
        write_reg(rsh_pkg::CFG_LOW, lo);
        write_reg(rsh_pkg::CFG_HIGH, hi);
        write_reg(rsh_pkg::CFG_LOG, 64'(lm));
        write_reg(rsh_pkg::CFG_SCALE, 64'(sc));
    endtask

    function automatic row_t blank_row();
        row_t r;
        r.is_reg  = 1'b0;
        r.idx     = '0;
        r.data    = '0;
        r.f       = rsh_pkg::FUNC_SET;
        r.sel     = '0;
        r.has_exp = 1'b0;
        r.exp     = '0;
        return r;
    endfunction

    function automatic void add_item(rsh_pkg::func_t f, logic [63:0] s, logic [5:0] sel);
        row_t r;
        r         = blank_row();
        r.f       = f;
        r.data    = s;
        r.sel     = sel;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_checked(rsh_pkg::func_t f, logic [63:0] s, logic [5:0] sel,
                                        stat_result_t e);
        row_t r;
        r         = blank_row();
        r.f       = f;
        r.data    = s;
        r.sel     = sel;
        r.has_exp = 1'b1;
        r.exp     = e;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_reg(logic [2:0] idx, logic [63:0] d);
        row_t r;
        r        = blank_row();
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.data   = d;
        dir_rows.push_back(r);
    endfunction

    // Sample biased towards the histogram window
    function automatic logic [63:0] pick_sample();
        logic [63:0] span;
        int          r;
        span = m_high - m_low;
        r    = $urandom_range(0, 99);
        if (r < 45)
        begin
            if (m_high <= m_low) return m_low + $urandom_range(0, 3);
            if (span == ALL1) return rand64();
            return m_low + (rand64() % (span + 1));
        end
        if (r < 55)
            case ($urandom_range(0, 5))
                0: return 0;
                1: return ALL1;
                2: return m_low;
                3: return m_high;
                4: return m_low + 1;
                default: return m_high - 1;
            endcase
        if (r < 75) return $urandom_range(0, 1000);
        if (r < 85) return rand64() >> $urandom_range(0, 63);
        return rand64();
    endfunction

    task automatic random_phase(int n);
        stat_result_t none;
        int           r;
        bit           idle_ok;
        none    = '0;
        idle_ok = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_item(rsh_pkg::FUNC_SET, pick_sample(), 6'($urandom), 0, none, idle_ok);
            else if (r < 70)
                send_item(rsh_pkg::FUNC_INC,
                          ($urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 50))),
                          6'($urandom), 0, none, idle_ok);
            else if (r < 96)
                send_item(rsh_pkg::FUNC_READ, rand64(), 6'($urandom), 0, none, idle_ok);
            else
                send_item(rsh_pkg::FUNC_CLEAR, rand64(), 6'($urandom), 0, none, idle_ok);
        end
    endtask

    // Receiver: random stalls, and one long hold-off on request
    initial
    begin : sink_blk
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 15) stall_left = gap_len();
            end
        end
    end

    // Main sequence
    initial
    begin : main_blk
        stat_result_t e;
        row_t         row;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = rsh_pkg::FUNC_SET;
        sample      = '0;
        bin_select  = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = rsh_pkg::CFG_BINS;
        cfg_data    = '0;
        row_has_exp = 1'b0;
        row_exp     = '0;
        errors      = 0;
        n_items     = 0;
        n_results   = 0;
        n_hits      = 0;
        n_regs      = 0;
        cycles      = 0;
        hold_req    = 1'b0;
        m_bins  = '0;
        m_low   = '0;
        m_high  = '0;
        m_log   = 1'b0;
        m_scale = '0;
        clear_stats();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset state, histogram disabled, extremes
        e = '{0, 0, 0, 0, 0, 0, NO_BIN};
        add_checked(rsh_pkg::FUNC_READ, 0, 6'd0, e);
        e = '{ALL1, ALL1, 1, ALL1, ALL1, 0, NO_BIN};
        add_checked(rsh_pkg::FUNC_SET, ALL1, 6'd0, e);
        e = '{0, 0, 2, 1, ALL1, 0, NO_BIN};
        add_checked(rsh_pkg::FUNC_INC, 1, 6'd63, e);
        e = '{0, 0, 2, 1, ALL1, 0, NO_BIN};
        add_checked(rsh_pkg::FUNC_READ, ALL1, 6'd63, e);
        e = '{0, 0, 0, 0, 0, 0, NO_BIN};
        add_checked(rsh_pkg::FUNC_CLEAR, ALL1, 6'd63, e);
        // Too many bins clamps to 64; edges at 0 and 64
        add_reg(rsh_pkg::CFG_BINS, 64'd127);
        add_reg(rsh_pkg::CFG_LOW, 64'd0);
        add_reg(rsh_pkg::CFG_HIGH, 64'd64);
        e = '{0, 0, 1, 0, 0, 0, 7'd0};
        add_checked(rsh_pkg::FUNC_SET, 0, 6'd0, e);
        e = '{ALL1, ALL1, 2, 0, ALL1, 0, 7'd63};
        add_checked(rsh_pkg::FUNC_SET, ALL1, 6'd0, e);
        add_item(rsh_pkg::FUNC_SET, 64'd32, 6'd0);
        add_item(rsh_pkg::FUNC_SET, 64'd63, 6'd0);
        add_item(rsh_pkg::FUNC_READ, 0, 6'd63);
        add_item(rsh_pkg::FUNC_READ, 0, 6'd0);
        // Two bins, then one bin, then a read outside the bins
        add_reg(rsh_pkg::CFG_BINS, 64'd2);
        add_item(rsh_pkg::FUNC_SET, 64'd10, 6'd0);
        add_item(rsh_pkg::FUNC_READ, 0, 6'd1);
        add_reg(rsh_pkg::CFG_BINS, 64'd1);
        add_item(rsh_pkg::FUNC_SET, 64'd5, 6'd0);
        add_item(rsh_pkg::FUNC_READ, 0, 6'd5);
        // Log mode, low edge one and then zero
        add_reg(rsh_pkg::CFG_BINS, 64'd16);
        add_reg(rsh_pkg::CFG_LOW, 64'd1);
        add_reg(rsh_pkg::CFG_HIGH, 64'h100_0000_0000);
        add_reg(rsh_pkg::CFG_LOG, 64'd1);
        add_reg(rsh_pkg::CFG_SCALE, 64'd6291456);
        add_item(rsh_pkg::FUNC_SET, 64'd1000, 6'd0);
        add_item(rsh_pkg::FUNC_SET, 64'h10_0000, 6'd0);
        add_item(rsh_pkg::FUNC_SET, 64'h0FF_FFFF_FFFF, 6'd0);
        add_item(rsh_pkg::FUNC_READ, 0, 6'd15);
        add_reg(rsh_pkg::CFG_LOW, 64'd0);
        add_item(rsh_pkg::FUNC_SET, 64'd1, 6'd0);
        add_item(rsh_pkg::FUNC_CLEAR, 0, 6'd0);
        add_item(rsh_pkg::FUNC_READ, 0, 6'd0);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_reg)
            begin
                wait_idle();
                write_reg(row.idx, row.data);
            end
            else
                send_item(row.f, row.data, row.sel, row.has_exp, row.exp, 1'b1);
        end

        // Random phases across linear and log settings
        set_regs(7'd10, 64'd100, 64'd1100, 1'b0, 32'd0);
        random_phase(PHASE_LEN);
        set_regs(7'd64, 64'd0, ALL1, 1'b0, 32'hFFFF_FFFF);
        hold_req = 1'b1;
        random_phase(PHASE_LEN);
        set_regs(7'd127, rand64(), rand64(), 1'b0, $urandom);
        random_phase(PHASE_LEN);
        set_regs(7'd3, 64'd50, 64'd50, 1'b0, 32'd0);
        random_phase(PHASE_LEN);
        set_regs(7'd16, 64'd1, 64'h100_0000_0000, 1'b1, 32'd6291456);
        random_phase(PHASE_LEN);
        set_regs(7'd64, 64'd1000, 64'd1000000000000, 1'b1, 32'hFFFF_FFFF);
        random_phase(PHASE_LEN);
        set_regs(7'd40, 64'd0, 64'h8000_0000_0000_0000, 1'b1, 32'h0100_0000);
        random_phase(PHASE_LEN);
        set_regs(7'd0, rand64(), rand64(), 1'b0, $urandom);
        random_phase(PHASE_LEN);

        // Drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (pending_results.size() != 0)
            report("results missing", 0, 64'(pending_results.size()));

        $display("ran %0d items, %0d results, %0d bin hits, %0d register writes",
                 n_items, n_results, n_hits, n_regs);
        $display("settings: linear and log binning, clamped, single, zero and wide bins");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
